// File: sv/pedt_pkg.sv
// Shared types and constants for the parabola envelope distance transform.
package pedt_pkg;
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_HV_RD,
        ST_HV_W1,
        ST_HV_M1,
        ST_HV_M2,
        ST_HQ_M1,
        ST_HQ_M2,
        ST_DIV,
        ST_FRAC,
        ST_CMP,
        ST_EM_RD,
        ST_EM_SEG,
        ST_EM_V,
        ST_EM_M1,
        ST_EM_M2,
        ST_EM_OUT
    } state_t;

    localparam int MAX_LEN = 4096;

    localparam logic [0:0] CMD_PUSH = 1'b0;
    localparam logic [0:0] CMD_PULL = 1'b1;
    localparam logic [0:0] REG_COEF_A = 1'b0;
    localparam logic [0:0] REG_COEF_B = 1'b1;
    localparam logic signed [47:0] BND_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] BND_MIN = 48'sh8000_0000_0000;

    typedef struct packed {
        logic        start;
        logic signed [63:0] num;
        logic [63:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic signed [63:0] quo;
        logic [63:0] rem;
    } div_rsp_t;
endpackage

// File: sv/pedt_divider.sv
// Iterative restoring divider: signed numerator, positive denominator, floor.
module pedt_divider
(
    input  logic               clk,
    input  logic               rst_n,
    input  pedt_pkg::div_req_t req,
    output pedt_pkg::div_rsp_t rsp
);
    import pedt_pkg::*;

    logic [63:0] mag_reg, mag_next;
    logic [63:0] rem_reg, rem_next;
    logic [63:0] den_reg, den_next;
    logic        neg_reg, neg_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [64:0] trial;
    logic [63:0] rem_sh;

    always_comb
    begin
        mag_next  = mag_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_sh    = {rem_reg[62:0], mag_reg[63]};
        trial     = {1'b0, rem_sh} - {1'b0, den_reg};
        if (req.start)
        begin
            neg_next  = req.num[63];
            mag_next  = req.num[63] ? 64'(-req.num) : 64'(req.num);
            den_next  = req.den;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial[64])
            begin
                rem_next = rem_sh;
                mag_next = {mag_reg[62:0], 1'b0};
            end
            else
            begin
                rem_next = trial[63:0];
                mag_next = {mag_reg[62:0], 1'b1};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    // floor correction for a negative numerator
    always_comb
    begin
        rsp.done = done_reg;
        if (neg_reg && rem_reg != '0)
        begin
            rsp.quo = -$signed(mag_reg) - 64'sd1;
            rsp.rem = den_reg - rem_reg;
        end
        else
        begin
            rsp.quo = neg_reg ? -$signed(mag_reg) : $signed(mag_reg);
            rsp.rem = rem_reg;
        end
    end

`ifndef SYNTHESIS
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while busy");
    a_den_nz: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> req.den != '0)
        else $error("divider zero denominator");
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("divider restarted while busy");
`endif
endmodule

// File: sv/parabola_envelope_distance_transform.sv
// Top level of the parabola envelope distance transform.
// A push (cmd=0) stores one sample and updates the upper envelope. The first
// sample of a line and a dropped sample leave busy low; any other push holds
// busy until its crossings are done. Each crossing takes products on the
// shared multiplier, two 64-step passes of the iterative divider (quotient,
// then fraction), and one compare step. A pull (cmd=1) while emitting holds
// busy while it walks the envelope boundaries; its result shows for
// one cycle on result_valid as busy drops and cannot be stalled. busy
// stays high while any item is in work. Stores are not cleared after reset.
module parabola_envelope_distance_transform
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:2]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               start,
    output logic               busy,
    input  logic               cmd,
    input  logic signed [31:0] sample_value,
    input  logic               is_last,
    output logic               result_valid,
    output logic signed [31:0] out_value,
    output logic [11:0]        out_index,
    output logic               out_last,
    output logic               out_truncated
);
    import pedt_pkg::*;

    localparam int AW = $clog2(MAX_LEN);
    localparam int LW = $clog2(MAX_LEN + 1);

    logic [23:0] coef_a_reg, coef_b_reg;
    state_t state_reg, state_next;

    // stores
    logic signed [31:0] samp_mem [MAX_LEN];
    logic [AW-1:0]      vert_mem [MAX_LEN];
    logic signed [47:0] bnd_mem  [MAX_LEN+1];

    logic [LW-1:0] len_reg, len_next;
    logic [AW-1:0] top_reg, top_next;
    logic [AW-1:0] k_reg, k_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic [AW-1:0] seg_reg, seg_next;
    logic          emit_reg, emit_next;
    logic          trunc_reg, trunc_next;
    logic [AW-1:0] q_reg, q_next;
    logic [AW-1:0] v_reg, v_next;
    logic signed [31:0] fq_reg, fq_next;
    logic signed [31:0] fv_reg;
    logic signed [65:0] acc_reg, acc_next;
    logic signed [47:0] s_reg, s_next;
    logic signed [47:0] bk_reg;
    logic [AW-1:0]      vk_reg;
    logic signed [63:0] quo_reg, quo_next;
    logic [15:0]        frac_reg, frac_next;
    logic               rv_reg, rv_next;
    logic signed [31:0] ov_reg, ov_next;
    logic               ol_reg, ol_next;
    logic               ot_reg, ot_next;

    // shared multiplier: one 25x26 signed product per cycle
    logic signed [24:0] mul_a;
    logic signed [25:0] mul_b;
    logic signed [50:0] mul_p;
    logic signed [50:0] prod_reg;
    logic signed [24:0] wa;
    logic signed [24:0] wb;

    // memory ports
    logic          s_we, v_we, b_we;
    logic [AW-1:0] s_wa, v_wa;
    logic [AW:0]   b_wa;
    logic signed [31:0] s_wd;
    logic [AW-1:0] v_wd;
    logic signed [47:0] b_wd;
    logic [AW-1:0] s_ra, v_ra;
    logic [AW:0]   b_ra;

    div_req_t dreq;
    div_rsp_t drsp;
    logic [63:0] den_reg, den_next;

    assign wa = (coef_a_reg == '0) ? 25'sd1 : $signed({1'b0, coef_a_reg});
    assign wb = $signed({coef_b_reg[23], coef_b_reg});
    assign mul_p = mul_a * mul_b;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_COEF_B) ? {{8{coef_b_reg[23]}}, coef_b_reg}
                                             : {8'd0, coef_a_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_a_reg <= 24'd65536;
            coef_b_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2] == REG_COEF_A)
                coef_a_reg <= pwdata[23:0];
            else
                coef_b_reg <= pwdata[23:0];
        end
    end

    pedt_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    always_ff @(posedge clk)
    begin
        if (s_we) samp_mem[s_wa] <= s_wd;
        if (v_we) vert_mem[v_wa] <= v_wd;
        if (b_we) bnd_mem[b_wa] <= b_wd;
        fv_reg <= samp_mem[s_ra];
        vk_reg <= vert_mem[v_ra];
        bk_reg <= bnd_mem[b_ra];
        prod_reg <= mul_p;
    end

    logic [AW:0] seg1;
    logic signed [47:0] qfix;
    logic signed [65:0] dval;
    logic signed [AW:0] dx;
    logic signed [AW:0] qmv;
    logic signed [AW+1:0] qpv;
    logic signed [AW:0] dqv;
    assign seg1 = {1'b0, seg_reg} + {{AW{1'b0}}, 1'b1};
    assign qfix = $signed({{(48-AW-16){1'b0}}, pos_reg, 16'd0});
    assign dx = $signed({1'b0, pos_reg}) - $signed({1'b0, v_reg});
    assign qmv = $signed({1'b0, q_reg}) - $signed({1'b0, vk_reg});
    assign qpv = $signed({2'b0, q_reg}) + $signed({2'b0, vk_reg});
    assign dqv = $signed({1'b0, q_reg}) - $signed({1'b0, v_reg});

    always_comb
    begin
        state_next = state_reg;
        len_next = len_reg; top_next = top_reg; k_next = k_reg;
        pos_next = pos_reg; seg_next = seg_reg; emit_next = emit_reg;
        trunc_next = trunc_reg; q_next = q_reg; v_next = v_reg;
        fq_next = fq_reg; acc_next = acc_reg; s_next = s_reg;
        quo_next = quo_reg; frac_next = frac_reg; den_next = den_reg;
        rv_next = 1'b0; ov_next = ov_reg; ol_next = ol_reg; ot_next = ot_reg;
        mul_a = wa; mul_b = '0;
        s_we = 1'b0; v_we = 1'b0; b_we = 1'b0;
        s_wa = q_reg; v_wa = k_reg; b_wa = {1'b0, k_reg};
        s_wd = fq_reg; v_wd = q_reg; b_wd = s_reg;
        s_ra = v_reg; v_ra = k_reg; b_ra = {1'b0, k_reg};
        dreq.start = 1'b0; dreq.num = acc_reg[63:0]; dreq.den = den_reg;
        dval = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (cmd == CMD_PUSH && !emit_reg)
                    begin
                        if (len_reg >= LW'(MAX_LEN))
                            trunc_next = 1'b1;
                        else
                        begin
                            s_we = 1'b1; s_wa = len_reg[AW-1:0];
                            s_wd = sample_value;
                            q_next = len_reg[AW-1:0]; fq_next = sample_value;
                            len_next = len_reg + LW'(1);
                            if (len_reg == '0)
                            begin
                                v_we = 1'b1; v_wa = '0; v_wd = '0;
                                top_next = '0;
                            end
                            else
                            begin
                                k_next = top_reg;
                                state_next = ST_HV_RD;
                            end
                        end
                        if (is_last)
                        begin
                            emit_next = 1'b1; pos_next = '0; seg_next = '0;
                        end
                    end
                    else if (cmd == CMD_PULL && emit_reg)
                        state_next = ST_EM_SEG;
                end
            end
            // crossing of vertex vert[k] with q
            // num = f[v]-f[q] + a*(q-v)*(q+v) + b*(q-v), den = 2*a*(q-v)
            ST_HV_RD: state_next = ST_HV_W1; // vk_reg, bk_reg load
            ST_HV_W1:
            begin
                v_next = vk_reg; s_ra = vk_reg; state_next = ST_HV_M1;
                // prod = (q-v)*(q+v)
                mul_a = 25'(qmv);
                mul_b = 26'(qpv);
            end
            ST_HV_M1:
            begin
                acc_next = 66'(fv_reg) - 66'(fq_reg);
                // prod = a*(q-v)*(q+v)
                mul_a = wa;
                mul_b = 26'(prod_reg);
                state_next = ST_HV_M2;
            end
            ST_HV_M2:
            begin
                acc_next = acc_reg + 66'(prod_reg);
                // prod = a*(q-v)
                mul_a = wa;
                mul_b = 26'(dqv);
                state_next = ST_HQ_M1;
            end
            ST_HQ_M1:
            begin
                den_next = 64'(prod_reg) << 1;
                // prod = b*(q-v)
                mul_a = wb;
                mul_b = 26'(dqv);
                state_next = ST_HQ_M2;
            end
            ST_HQ_M2:
            begin
                acc_next = acc_reg + 66'(prod_reg);
                dreq.start = 1'b1;
                dreq.num = 64'(acc_reg + 66'(prod_reg));
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (drsp.done)
                begin
                    quo_next = drsp.quo;
                    // fraction: (rem << 16) / den, second pass
                    acc_next = 66'(drsp.rem << 16);
                    state_next = ST_FRAC;
                    dreq.start = 1'b1;
                    dreq.num = 64'(drsp.rem << 16);
                end
            end
            ST_FRAC:
            begin
                if (drsp.done)
                begin
                    frac_next = drsp.quo[15:0];
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                if (quo_reg > 64'sd2147483647) s_next = BND_MAX;
                else if (quo_reg < -64'sd2147483648) s_next = BND_MIN;
                else s_next = {quo_reg[31:0], frac_reg};
                if (k_reg != '0 && s_next <= bk_reg)
                begin
                    k_next = k_reg - AW'(1);
                    v_ra = k_reg - AW'(1); b_ra = {1'b0, k_reg - AW'(1)};
                    state_next = ST_HV_W1;
                end
                else
                begin
                    v_we = 1'b1; b_we = 1'b1;
                    v_wa = k_reg + AW'(1); b_wa = {1'b0, k_reg + AW'(1)};
                    v_wd = q_reg; b_wd = s_next;
                    top_next = k_reg + AW'(1);
                    state_next = ST_IDLE;
                end
            end
            // emission: advance segment one boundary per ST_EM_SEG/ST_EM_RD pass
            ST_EM_SEG:
            begin
                b_ra = seg1; v_ra = seg_reg;
                state_next = ST_EM_RD;
            end
            ST_EM_RD:
            begin
                if (seg_reg < top_reg && bk_reg < qfix)
                begin
                    seg_next = seg1[AW-1:0];
                    state_next = ST_EM_SEG;
                end
                else
                begin
                    s_ra = vk_reg;
                    v_next = vk_reg;
                    state_next = ST_EM_V;
                end
            end
            ST_EM_V:
            begin
                // prod = dx*dx
                mul_a = 25'(dx); mul_b = 26'(dx);
                state_next = ST_EM_M1;
            end
            ST_EM_M1:
            begin
                acc_next = 66'(fv_reg);
                // prod = a*dx*dx
                mul_a = wa; mul_b = 26'(prod_reg);
                state_next = ST_EM_M2;
            end
            ST_EM_M2:
            begin
                acc_next = acc_reg - 66'(prod_reg);
                // prod = b*dx
                mul_a = wb; mul_b = 26'(dx);
                state_next = ST_EM_OUT;
            end
            ST_EM_OUT:
            begin
                dval = acc_reg + 66'(prod_reg);
                if (dval > 66'sd2147483647) ov_next = 32'sh7FFF_FFFF;
                else if (dval < -66'sd2147483648) ov_next = 32'sh8000_0000;
                else ov_next = dval[31:0];
                rv_next = 1'b1;
                ot_next = trunc_reg;
                ol_next = ({1'b0, pos_reg} + {{AW{1'b0}}, 1'b1}) >= len_reg;
                if (ol_next)
                begin
                    len_next = '0; top_next = '0; pos_next = '0;
                    seg_next = '0; emit_next = 1'b0; trunc_next = 1'b0;
                end
                else
                    pos_next = pos_reg + AW'(1);
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            len_reg <= '0; top_reg <= '0; pos_reg <= '0; seg_reg <= '0;
            emit_reg <= 1'b0; trunc_reg <= 1'b0; rv_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg <= len_next; top_reg <= top_next; pos_reg <= pos_next;
            seg_reg <= seg_next; emit_reg <= emit_next; rv_reg <= rv_next;
            trunc_reg <= trunc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg <= k_next; q_reg <= q_next; v_reg <= v_next; fq_reg <= fq_next;
        acc_reg <= acc_next; s_reg <= s_next; quo_reg <= quo_next;
        frac_reg <= frac_next; den_reg <= den_next; ov_reg <= ov_next;
        ol_reg <= ol_next; ot_reg <= ot_next;
    end

    assign busy = (state_reg != ST_IDLE);
    assign result_valid = rv_reg;
    assign out_value = ov_reg;
    assign out_index = v_reg;
    assign out_last = ol_reg;
    assign out_truncated = ot_reg;

`ifndef SYNTHESIS
    a_rv_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !$past(result_valid))
        else $error("result held two cycles");
    a_top_len: assert property (@(posedge clk) disable iff (!rst_n)
        emit_reg |-> len_reg != '0)
        else $error("emitting empty line");
    a_busy_rv: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(state_reg == ST_EM_OUT))
        else $error("result outside emit");
`endif
endmodule

// File: sim/tb.sv
// Self-checking testbench for the parabola envelope distance transform.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pedt_pkg::*;

    localparam int LINE_MAX  = MAX_LEN;
    localparam int SETTLE    = 24;   // extra wait after the last expected result arrives
    localparam int RAND_GOAL = 1250;

    typedef struct {
        logic        op;
        logic [31:0] value;
        logic        last;
    } cmd_item_t;

    typedef struct {
        logic signed [31:0] value;
        logic [11:0]        index;
        logic               last;
        logic               trunc;
    } envelope_out_t;

    logic clk, rst_n;
    logic psel, penable, pwrite;
    logic [2:2] paddr;
    logic [31:0] pwdata, prdata;
    logic pready;
    logic start, busy, cmd, is_last;
    logic signed [31:0] sample_value;
    logic result_valid;
    logic signed [31:0] out_value;
    logic [11:0] out_index;
    logic out_last, out_truncated;

    parabola_envelope_distance_transform dut (.*);

    // Mirror of the block's state.
    logic [23:0]        m_coef_a;
    logic [23:0]        m_coef_b;
    logic signed [31:0] m_samples [LINE_MAX];
    logic [11:0]        m_vertex [LINE_MAX];
    longint             m_bound [LINE_MAX + 1];
    int                 m_len, m_top, m_pos, m_seg;
    bit                 m_emitting, m_trunc;

    cmd_item_t     cmd_fifo [$];
    envelope_out_t expected_scores [$];
    cmd_item_t     cur;
    int            gap_left;
    bit            no_gaps;
    int            mismatches, results_seen, lines_run, reg_writes, rand_items;

    function automatic longint weight_a();
        return (m_coef_a == 0) ? 64'sd1 : longint'(m_coef_a);
    endfunction

    function automatic longint coef_b_s();
        return longint'($signed(m_coef_b));
    endfunction

    // h(x) = f[x] - a*x^2 - b*x
    function automatic longint parab_height(int x);
        longint xi;
        xi = x;
        return longint'(m_samples[x]) - weight_a() * xi * xi - coef_b_s() * xi;
    endfunction

    // Floored Q32.16 crossing of the parabolas at v and q; integer part saturates.
    function automatic longint cross_point(int v, int q);
        longint num, den, quo, rem;
        num = parab_height(v) - parab_height(q);
        den = 2 * weight_a() * longint'(q - v);
        quo = num / den;
        rem = num % den;
        if (rem < 0)
        begin
            quo = quo - 1;
            rem = rem + den;
        end
        if (quo > 64'sd2147483647)
            return 64'sh7FFF_FFFF_FFFF;
        if (quo < -64'sd2147483648)
            return -64'sh8000_0000_0000;
        return quo * 65536 + (rem * 65536) / den;
    endfunction

    function automatic void clear_line();
        m_len = 0;
        m_top = 0;
        m_pos = 0;
        m_seg = 0;
        m_trunc = 0;
        m_emitting = 0;
    endfunction

    // Advance the mirror by one accepted beat; queue a result for a pull.
    function automatic void transform_step(cmd_item_t it);
        int k, q, v;
        longint s, dx, val;
        envelope_out_t r;
        if (it.op == CMD_PUSH)
        begin
            if (m_emitting)
                return;
            if (m_len >= LINE_MAX)
                m_trunc = 1;
            else
            begin
                q = m_len;
                m_samples[q] = it.value;
                if (q == 0)
                begin
                    m_vertex[0] = 0;
                    m_top = 0;
                end
                else
                begin
                    k = m_top;
                    s = cross_point(m_vertex[k], q);
                    while (k > 0 && s <= m_bound[k])
                    begin
                        k--;
                        s = cross_point(m_vertex[k], q);
                    end
                    k++;
                    m_vertex[k] = q;
                    m_bound[k] = s;
                    m_top = k;
                end
                m_len = q + 1;
            end
            if (it.last)
            begin
                m_emitting = 1;
                m_pos = 0;
                m_seg = 0;
            end
        end
        else
        begin
            if (!m_emitting)
                return;
            q = m_pos;
            while (m_seg < m_top && m_bound[m_seg + 1] < longint'(q) * 65536)
                m_seg++;
            v = m_vertex[m_seg];
            dx = q - v;
            val = longint'(m_samples[v]) - weight_a() * dx * dx + coef_b_s() * dx;
            if (val > 64'sd2147483647)
                val = 64'sd2147483647;
            if (val < -64'sd2147483648)
                val = -64'sd2147483648;
            r.value = val[31:0];
            r.index = v[11:0];
            r.last  = (q + 1 >= m_len);
            r.trunc = m_trunc;
            expected_scores.push_back(r);
            if (r.last)
                clear_line();
            else
                m_pos = q + 1;
        end
    endfunction

    // Mostly back-to-back, sometimes short gaps, rarely long ones.
    function automatic int pick_gap();
        int p;
        if (no_gaps)
            return 0;
        p = $urandom_range(99);
        if (p < 60)
            return 0;
        if (p < 92)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // Driver: hold a beat until accepted, then advance after a random gap.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start <= 0;
            cmd <= 0;
            sample_value <= '0;
            is_last <= 0;
            gap_left <= 0;
        end
        else
        begin
            if (start && !busy)
                transform_step(cur);
            if (start && busy)
                ;   // hold the beat
            else if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                start <= 0;
            end
            else if (cmd_fifo.size() > 0)
            begin
                cur = cmd_fifo.pop_front();
                cmd <= cur.op;
                sample_value <= cur.value;
                is_last <= cur.last;
                start <= 1;
                gap_left <= pick_gap();
            end
            else
                start <= 0;
        end
    end

    // Monitor: compare each strobed result against the oldest expectation.
    always @(posedge clk)
    begin
        envelope_out_t e;
        if (rst_n && result_valid)
        begin
            results_seen++;
            if (expected_scores.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: value %0d index %0d", out_value, out_index);
            end
            else
            begin
                e = expected_scores.pop_front();
                if (out_value !== e.value || out_index !== e.index ||
                    out_last !== e.last || out_truncated !== e.trunc)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp v=%0d i=%0d l=%0b t=%0b got v=%0d i=%0d l=%0b t=%0b",
                                 e.value, e.index, e.last, e.trunc,
                                 out_value, out_index, out_last, out_truncated);
                end
            end
        end
    end

    task automatic wait_idle();
        while (cmd_fifo.size() > 0 || start || expected_scores.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Register write with setup and access phases; takes effect at the access edge.
    task automatic reg_write(logic idx, logic [23:0] val);
        wait_idle();
        psel <= 1;
        pwrite <= 1;
        penable <= 0;
        paddr <= idx;
        pwdata <= {{8{idx == REG_COEF_B ? val[23] : 1'b0}}, val};
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        if (idx == REG_COEF_A)
            m_coef_a = val;
        else
            m_coef_b = val;
        reg_writes++;
    endtask

    function automatic logic [31:0] pick_sample(int mode);
        case (mode)
            0: return $urandom();
            1: return $urandom_range(32'h0010_0000) - 32'h0008_0000;
            2: return ($urandom_range(1)) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return $urandom_range(32'h0000_4000) - 32'h0000_2000;
        endcase
    endfunction

    // Queue one line: pushes, then one pull per stored position. Optional noise
    // adds an ignored pull before the line and an ignored push after the last sample.
    task automatic queue_line(int len, int mode, bit noise);
        cmd_item_t it;
        int n;
        n = (len > LINE_MAX) ? LINE_MAX : len;
        if (noise)
            cmd_fifo.push_back('{CMD_PULL, $urandom(), $urandom_range(1)});
        for (int i = 0; i < len; i++)
        begin
            it.op = CMD_PUSH;
            it.value = pick_sample(mode);
            it.last = (i == len - 1);
            cmd_fifo.push_back(it);
        end
        if (noise)
            cmd_fifo.push_back('{CMD_PUSH, $urandom(), $urandom_range(1)});
        for (int i = 0; i < n; i++)
            cmd_fifo.push_back('{CMD_PULL, $urandom(), $urandom_range(1)});
        lines_run++;
        rand_items += len + n;
    endtask

    initial
    begin
        rst_n = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        no_gaps = 0;
        m_coef_a = 24'd65536;
        m_coef_b = 24'd0;
        clear_line();
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: extreme scores under reset weights, ignored beats, single sample.
        cmd_fifo.push_back('{CMD_PULL, 32'h0, 1'b0});          // pull while loading
        cmd_fifo.push_back('{CMD_PUSH, 32'h7FFF_FFFF, 1'b0});
        cmd_fifo.push_back('{CMD_PUSH, 32'h8000_0000, 1'b0});
        cmd_fifo.push_back('{CMD_PUSH, 32'h0000_0000, 1'b0});
        cmd_fifo.push_back('{CMD_PUSH, 32'h7FFF_FFFF, 1'b1});
        cmd_fifo.push_back('{CMD_PUSH, 32'h1234_5678, 1'b1});  // push while emitting
        repeat (4) cmd_fifo.push_back('{CMD_PULL, 32'hFFFF_FFFF, 1'b1});
        cmd_fifo.push_back('{CMD_PUSH, 32'hFFFF_FFFF, 1'b1});  // one-sample line
        cmd_fifo.push_back('{CMD_PULL, 32'h0, 1'b0});
        // Equal scores: an exact tie at a boundary goes to the earlier sample.
        repeat (3) cmd_fifo.push_back('{CMD_PUSH, 32'h0001_0000, 1'b0});
        cmd_fifo.push_back('{CMD_PUSH, 32'h0001_0000, 1'b1});
        repeat (4) cmd_fifo.push_back('{CMD_PULL, 32'h0, 1'b0});

        // Weight extremes, zero quadratic weight among them.
        reg_write(REG_COEF_A, 24'd0);
        reg_write(REG_COEF_B, 24'h7F_FFFF);
        queue_line(6, 2, 0);
        reg_write(REG_COEF_A, 24'hFF_FFFF);
        reg_write(REG_COEF_B, 24'h80_0000);
        queue_line(6, 2, 0);
        reg_write(REG_COEF_A, 24'd1);
        queue_line(5, 0, 0);

        // Overlong line: drop the tail and end it on a dropped push.
        wait_idle();
        no_gaps = 1;
        reg_write(REG_COEF_A, 24'd65536);
        reg_write(REG_COEF_B, 24'd0);
        queue_line(LINE_MAX + 3, 3, 0);
        wait_idle();
        no_gaps = 0;
        rand_items = 0;

        // Random lines under changing weights; some stretches without gaps.
        while (rand_items < RAND_GOAL)
        begin
            if ($urandom_range(3) == 0)
            begin
                reg_write(REG_COEF_A, ($urandom_range(4) == 0) ? $urandom() : $urandom_range(24'h04_0000));
                reg_write(REG_COEF_B, $urandom());
            end
            no_gaps = ($urandom_range(4) == 0);
            if ($urandom_range(9) == 0)
                queue_line($urandom_range(120, 40), $urandom_range(3), $urandom_range(1));
            else
                queue_line($urandom_range(24, 1), $urandom_range(3), $urandom_range(3) == 0);
        end

        wait_idle();
        repeat (SETTLE) @(posedge clk);
        if (expected_scores.size() > 0)
        begin
            mismatches++;
            $display("%0d expected results never arrived", expected_scores.size());
        end
        $display("Covered %0d lines including one past the length limit, %0d register writes,",
                 lines_run, reg_writes);
        $display("%0d results checked, %0d mismatches", results_seen, mismatches);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Watchdog: well beyond the slowest legal run.
    initial
    begin
        #(20ns * 12_000_000);
        $display("timeout waiting for the block");
        $display("FAILED: results differ");
        $finish;
    end
endmodule
